// ===== rtl/hbed_pkg.sv =====
// Shared types, constants and functions of the hashed block error decider.
package hbed_pkg;

  localparam int COUNTER_BITS_DEFAULT = 32;

  localparam logic [63:0] MIX_GOLDEN = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_C1     = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_C2     = 64'h94D049BB133111EB;

  localparam logic [16:0] Q16_ONE           = 17'd65536;
  localparam logic [15:0] WINDOW_LENGTH_RST = 16'd1000;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 64;
  localparam int HASH_STEPS     = 8;
  localparam int STEP_BITS      = $clog2(HASH_STEPS);
  localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(HASH_STEPS - 1);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_HASH_SEED       = 3'd0,
    REG_LINK_DIRECTION  = 3'd1,
    REG_EMULATION_EN    = 3'd2,
    REG_ERROR_THRESHOLD = 3'd3,
    REG_PROTECT_RETX    = 3'd4,
    REG_WINDOW_LENGTH   = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PART_LL,
    PART_HL,
    PART_LH
  } mul_part_t;

  typedef enum logic [2:0] {
    Z_HOLD,
    Z_SEED,
    Z_FOLD,
    Z_XS27,
    Z_XS31
  } z_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MA0,
    S_MA1,
    S_MA2,
    S_MA3,
    S_XS,
    S_MB0,
    S_MB1,
    S_MB2,
    S_MB3,
    S_FIN,
    S_FOLD,
    S_DECIDE
  } state_t;

  typedef struct packed {
    logic                 start;
    z_op_t                z_op;
    logic [STEP_BITS-1:0] step;
    logic                 mul_en;
    mul_part_t            mul_part;
    logic                 const_sel;
    logic                 acc_en;
    mul_part_t            acc_part;
    logic                 decide;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

  // First half of a mix step: add the golden increment, then xor-shift by 30.
  function automatic logic [63:0] premix(input logic [63:0] v);
    logic [63:0] t;
    t = v + MIX_GOLDEN;
    return t ^ (t >> 30);
  endfunction

  // Redundancy version 0,2,3,1 maps to rounds 0,1,2,3.
  function automatic logic [1:0] round_of(input logic [1:0] rv);
    logic [1:0] r;
    case (rv)
      2'd0:    r = 2'd0;
      2'd1:    r = 2'd3;
      2'd2:    r = 2'd1;
      default: r = 2'd2;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/hashed_block_error_decider_top.sv =====
// Top level of the hashed block error decider: sequencer plus hash and statistics datapath.
// Each word runs through eight mix steps, sequenced around the single shared 32x32 multiplier
//   (three partial products per 64-bit multiply); a new word is accepted only after the
//   previous word has been decided, and deciding waits while the output register is busy.
// The next input word is accepted while a finished result still waits in the output register.
// Reset (rst, synchronous, active high) clears statistics, the output valid flag and
//   loads register defaults (window length 1000, all others zero).
module hashed_block_error_decider_top
  import hbed_pkg::*;
#(
  parameter int COUNTER_BITS = COUNTER_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  // configuration write port
  input  logic                      cfg_write_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  // input word
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [15:0]               rnti,
  input  logic [9:0]                frame_number,
  input  logic [7:0]                slot_number,
  input  logic [7:0]                harq_process,
  input  logic [1:0]                redundancy_version,
  input  logic [4:0]                mcs_index,
  input  logic                      access_done,
  // result word
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      block_fails,
  output logic                      was_counted,
  output logic [1:0]                harq_round,
  output logic                      window_closed,
  output logic [31:0]               window_blocks,
  output logic [31:0]               window_failures,
  output logic [4:0]                window_mcs_low,
  output logic [4:0]                window_mcs_high,
  output logic [31:0]               total_blocks,
  output logic [31:0]               total_failures,
  output logic [31:0]               total_retransmissions
);

  // Commands flow from the sequencer to the datapath; the datapath reports only
  // whether its output register can take a new result.
  cmd_t    cmd;
  status_t status;

  // Sequencer: accept a word, seed the hash, then run each mix step as
  // multiply, xor-shift, multiply, xor-shift and fold in the next field, except after the last step.
  hbed_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: configuration registers, latched word, hash registers with the
  // shared multiplier, saturating counters and the result register.
  hbed_datapath #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_datapath (
    .clk                   (clk),
    .rst                   (rst),
    .cfg_write_en          (cfg_write_en),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .rnti                  (rnti),
    .frame_number          (frame_number),
    .slot_number           (slot_number),
    .harq_process          (harq_process),
    .redundancy_version    (redundancy_version),
    .mcs_index             (mcs_index),
    .access_done           (access_done),
    .cmd                   (cmd),
    .status                (status),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .block_fails           (block_fails),
    .was_counted           (was_counted),
    .harq_round            (harq_round),
    .window_closed         (window_closed),
    .window_blocks         (window_blocks),
    .window_failures       (window_failures),
    .window_mcs_low        (window_mcs_low),
    .window_mcs_high       (window_mcs_high),
    .total_blocks          (total_blocks),
    .total_failures        (total_failures),
    .total_retransmissions (total_retransmissions)
  );

endmodule

// ===== rtl/hbed_ctrl.sv =====
// Sequencer that walks the eight mix steps and issues datapath commands.
module hbed_ctrl
  import hbed_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t               state, state_next;
  logic [STEP_BITS-1:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next    = state;
    step_next     = step;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.z_op      = Z_HOLD;
    cmd.mul_part  = PART_LL;
    cmd.acc_part  = PART_LL;
    cmd.step      = step;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          cmd.z_op   = Z_SEED;
          step_next  = '0;
          state_next = S_MA0;
        end
      end
      S_MA0: begin
        cmd.mul_en = 1'b1;
        state_next = S_MA1;
      end
      S_MA1: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_part = PART_HL;
        cmd.acc_en   = 1'b1;
        state_next   = S_MA2;
      end
      S_MA2: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_part = PART_LH;
        cmd.acc_en   = 1'b1;
        cmd.acc_part = PART_HL;
        state_next   = S_MA3;
      end
      S_MA3: begin
        cmd.acc_en   = 1'b1;
        cmd.acc_part = PART_LH;
        state_next   = S_XS;
      end
      S_XS: begin
        cmd.z_op   = Z_XS27;
        state_next = S_MB0;
      end
      S_MB0: begin
        cmd.mul_en    = 1'b1;
        cmd.const_sel = 1'b1;
        state_next    = S_MB1;
      end
      S_MB1: begin
        cmd.mul_en    = 1'b1;
        cmd.const_sel = 1'b1;
        cmd.mul_part  = PART_HL;
        cmd.acc_en    = 1'b1;
        state_next    = S_MB2;
      end
      S_MB2: begin
        cmd.mul_en    = 1'b1;
        cmd.const_sel = 1'b1;
        cmd.mul_part  = PART_LH;
        cmd.acc_en    = 1'b1;
        cmd.acc_part  = PART_HL;
        state_next    = S_MB3;
      end
      S_MB3: begin
        cmd.acc_en   = 1'b1;
        cmd.acc_part = PART_LH;
        state_next   = S_FIN;
      end
      S_FIN: begin
        cmd.z_op = Z_XS31;
        if (step == LAST_STEP) begin
          state_next = S_DECIDE;
        end else begin
          step_next  = step + 1'b1;
          state_next = S_FOLD;
        end
      end
      S_FOLD: begin
        cmd.z_op   = Z_FOLD;
        state_next = S_MA0;
      end
      S_DECIDE: begin
        // hold until the output register is free or being emptied
        if (!status.out_busy) begin
          cmd.decide = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/hbed_datapath.sv =====
// Hash datapath with shared 32x32 multiplier, statistics counters and result register.
module hbed_datapath
  import hbed_pkg::*;
#(
  parameter int COUNTER_BITS = COUNTER_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic [15:0]               rnti,
  input  logic [9:0]                frame_number,
  input  logic [7:0]                slot_number,
  input  logic [7:0]                harq_process,
  input  logic [1:0]                redundancy_version,
  input  logic [4:0]                mcs_index,
  input  logic                      access_done,
  input  cmd_t                      cmd,
  output status_t                   status,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      block_fails,
  output logic                      was_counted,
  output logic [1:0]                harq_round,
  output logic                      window_closed,
  output logic [31:0]               window_blocks,
  output logic [31:0]               window_failures,
  output logic [4:0]                window_mcs_low,
  output logic [4:0]                window_mcs_high,
  output logic [31:0]               total_blocks,
  output logic [31:0]               total_failures,
  output logic [31:0]               total_retransmissions
);

  localparam int CB = COUNTER_BITS;

  function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] c);
    return (&c) ? c : c + CB'(1);
  endfunction

  // configuration
  logic [63:0] hash_seed;
  logic        link_direction;
  logic        emulation_enabled;
  logic [16:0] error_threshold;
  logic        protect_retransmissions;
  logic [15:0] window_length;

  // latched item
  logic [15:0] lat_rnti;
  logic [9:0]  lat_frame;
  logic [7:0]  lat_slot;
  logic [7:0]  lat_harq;
  logic [1:0]  lat_rv;
  logic [4:0]  lat_mcs;
  logic        lat_access;

  // hash working registers
  logic [63:0] z;
  logic [63:0] prod;
  logic [63:0] acc;
  logic [63:0] fold_val;
  logic [63:0] mul_const;
  logic [31:0] mul_a;
  logic [31:0] mul_b;

  // statistics
  logic [CB-1:0] win_blocks;
  logic [CB-1:0] win_fails;
  logic [4:0]    win_mcs_min;
  logic [4:0]    win_mcs_max;
  logic [CB-1:0] all_blocks;
  logic [CB-1:0] all_fails;
  logic [CB-1:0] retx_blocks;

  // decision
  logic [16:0]   thr_eff;
  logic [1:0]    rnd;
  logic          counted;
  logic          fail;
  logic          closed;
  logic [CB-1:0] win_blocks_next;
  logic [CB-1:0] win_fails_next;
  logic [4:0]    win_mcs_min_next;
  logic [4:0]    win_mcs_max_next;
  logic [CB-1:0] all_blocks_next;
  logic [CB-1:0] all_fails_next;
  logic [CB-1:0] retx_blocks_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_seed               <= '0;
      link_direction          <= 1'b0;
      emulation_enabled       <= 1'b0;
      error_threshold         <= '0;
      protect_retransmissions <= 1'b0;
      window_length           <= WINDOW_LENGTH_RST;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_HASH_SEED:       hash_seed               <= cfg_data;
        REG_LINK_DIRECTION:  link_direction          <= cfg_data[0];
        REG_EMULATION_EN:    emulation_enabled       <= cfg_data[0];
        REG_ERROR_THRESHOLD: error_threshold         <= cfg_data[16:0];
        REG_PROTECT_RETX:    protect_retransmissions <= cfg_data[0];
        REG_WINDOW_LENGTH:   window_length           <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      lat_rnti   <= rnti;
      lat_frame  <= frame_number;
      lat_slot   <= slot_number;
      lat_harq   <= harq_process;
      lat_rv     <= redundancy_version;
      lat_mcs    <= mcs_index;
      lat_access <= access_done;
    end
  end

  always_comb begin
    case (cmd.step)
      3'd1:    fold_val = {63'd0, link_direction};
      3'd2:    fold_val = {48'd0, lat_rnti};
      3'd3:    fold_val = {54'd0, lat_frame};
      3'd4:    fold_val = {56'd0, lat_slot};
      3'd5:    fold_val = {56'd0, lat_harq};
      3'd6:    fold_val = {62'd0, lat_rv};
      default: fold_val = '0;
    endcase
  end

  // Low 64 bits of z * C from three 32x32 partial products.
  assign mul_const = cmd.const_sel ? MIX_C2 : MIX_C1;
  assign mul_a     = (cmd.mul_part == PART_HL) ? z[63:32] : z[31:0];
  assign mul_b     = (cmd.mul_part == PART_LH) ? mul_const[63:32] : mul_const[31:0];

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= 64'(mul_a) * 64'(mul_b);
    end
    if (cmd.acc_en) begin
      case (cmd.acc_part)
        PART_LL: acc <= prod;
        default: acc <= acc + {prod[31:0], 32'd0};
      endcase
    end
    case (cmd.z_op)
      Z_SEED:  z <= premix(hash_seed);
      Z_FOLD:  z <= premix(z ^ fold_val);
      Z_XS27:  z <= acc ^ (acc >> 27);
      Z_XS31:  z <= acc ^ (acc >> 31);
      default: ;
    endcase
  end

  always_comb begin
    thr_eff = (error_threshold > Q16_ONE) ? Q16_ONE : error_threshold;
    rnd     = round_of(lat_rv);
    counted = emulation_enabled && lat_access && (thr_eff != '0) &&
              !(protect_retransmissions && (rnd != 2'd0));
    fail    = counted && ({1'b0, z[63:48]} < thr_eff);

    win_blocks_next  = win_blocks;
    win_fails_next   = win_fails;
    win_mcs_min_next = win_mcs_min;
    win_mcs_max_next = win_mcs_max;
    all_blocks_next  = all_blocks;
    all_fails_next   = all_fails;
    retx_blocks_next = retx_blocks;
    if (counted) begin
      if (win_blocks == '0) begin
        win_mcs_min_next = lat_mcs;
        win_mcs_max_next = lat_mcs;
      end else begin
        if (lat_mcs < win_mcs_min) win_mcs_min_next = lat_mcs;
        if (lat_mcs > win_mcs_max) win_mcs_max_next = lat_mcs;
      end
      win_blocks_next = sat_inc(win_blocks);
      all_blocks_next = sat_inc(all_blocks);
      if (rnd != 2'd0) retx_blocks_next = sat_inc(retx_blocks);
      if (fail) begin
        win_fails_next = sat_inc(win_fails);
        all_fails_next = sat_inc(all_fails);
      end
    end
    closed = counted && (window_length != '0) &&
             (win_blocks_next >= CB'(window_length));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_blocks  <= '0;
      win_fails   <= '0;
      win_mcs_min <= '0;
      win_mcs_max <= '0;
      all_blocks  <= '0;
      all_fails   <= '0;
      retx_blocks <= '0;
    end else if (cmd.decide) begin
      win_blocks  <= closed ? '0 : win_blocks_next;
      win_fails   <= closed ? '0 : win_fails_next;
      win_mcs_min <= win_mcs_min_next;
      win_mcs_max <= win_mcs_max_next;
      all_blocks  <= all_blocks_next;
      all_fails   <= all_fails_next;
      retx_blocks <= retx_blocks_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.decide) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      block_fails           <= fail;
      was_counted           <= counted;
      harq_round            <= rnd;
      window_closed         <= closed;
      window_blocks         <= 32'(win_blocks_next);
      window_failures       <= 32'(win_fails_next);
      window_mcs_low        <= win_mcs_min_next;
      window_mcs_high       <= win_mcs_max_next;
      total_blocks          <= 32'(all_blocks_next);
      total_failures        <= 32'(all_fails_next);
      total_retransmissions <= 32'(retx_blocks_next);
    end
  end

  assign status.out_busy = out_valid && !out_ready;

endmodule
